>>> rtl/core/sfr_pkg.sv
package sfr_pkg;

    localparam logic [7:0]  SYNC_FIRST      = 8'hB5;
    localparam logic [7:0]  SYNC_SECOND     = 8'h62;
    localparam logic [15:0] MAX_LEN_RESET   = 16'd119;

    localparam logic [1:0]  EV_NONE         = 2'd0;
    localparam logic [1:0]  EV_GOOD         = 2'd1;
    localparam logic [1:0]  EV_BAD_SUM      = 2'd2;
    localparam logic [1:0]  EV_TOO_LONG     = 2'd3;

    typedef struct packed {
        logic [1:0]  event_res;
        logic [7:0]  class_id;
        logic [7:0]  message_id;
        logic [15:0] payload_length;
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic [15:0] payload_index;
    } sfr_result_t;

endpackage

>>> rtl/core/sfr_ifs.sv
interface sfr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface sfr_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  event_res;
    logic [7:0]  class_id;
    logic [7:0]  message_id;
    logic [15:0] payload_length;
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;

    modport source (output valid, output event_res, output class_id, output message_id,
                    output payload_length, output payload_valid, output payload_byte,
                    output payload_index, input ready);
    modport sink (input valid, input event_res, input class_id, input message_id,
                  input payload_length, input payload_valid, input payload_byte,
                  input payload_index, output ready);
endinterface

>>> rtl/core/sfr_parser.sv
module sfr_parser #(
    parameter logic [15:0] MAX_LEN_INIT = sfr_pkg::MAX_LEN_RESET
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [15:0]         cfg_wdata,
    input  logic                take,
    input  logic [7:0]          rx_byte,
    output sfr_pkg::sfr_result_t result
);

    localparam logic [2:0] PH_HUNT    = 3'd0;
    localparam logic [2:0] PH_CLASS   = 3'd1;
    localparam logic [2:0] PH_MSG     = 3'd2;
    localparam logic [2:0] PH_LEN_LO  = 3'd3;
    localparam logic [2:0] PH_LEN_HI  = 3'd4;
    localparam logic [2:0] PH_PAYLOAD = 3'd5;
    localparam logic [2:0] PH_CK_A    = 3'd6;
    localparam logic [2:0] PH_CK_B    = 3'd7;

    logic [15:0] max_len_reg;
    logic [2:0]  phase_reg, phase_next;
    logic [7:0]  prev_reg;
    logic [7:0]  sum_a_reg, sum_a_next;
    logic [7:0]  sum_b_reg, sum_b_next;
    logic [7:0]  rsum_a_reg, rsum_a_next;
    logic [7:0]  class_reg, class_next;
    logic [7:0]  msg_reg, msg_next;
    logic [15:0] length_reg, length_next;
    logic [15:0] seen_reg, seen_next;

    logic        sync_hit;
    logic [7:0]  sum_a_add;
    logic [7:0]  sum_b_add;
    logic [15:0] len_hi;
    logic [15:0] seen_inc;
    logic [1:0]  ev;
    logic        pv;
    logic [7:0]  pb;
    logic [15:0] pi;

    assign sync_hit  = (rx_byte == sfr_pkg::SYNC_SECOND) && (prev_reg == sfr_pkg::SYNC_FIRST);
    assign sum_a_add = sum_a_reg + rx_byte;
    assign sum_b_add = sum_b_reg + sum_a_add;
    assign len_hi    = {rx_byte, length_reg[7:0]};
    assign seen_inc  = seen_reg + 16'd1;

    always_comb
    begin
        phase_next  = phase_reg;
        sum_a_next  = sum_a_reg;
        sum_b_next  = sum_b_reg;
        rsum_a_next = rsum_a_reg;
        class_next  = class_reg;
        msg_next    = msg_reg;
        length_next = length_reg;
        seen_next   = seen_reg;
        ev          = sfr_pkg::EV_NONE;
        pv          = 1'b0;
        pb          = 8'd0;
        pi          = 16'd0;
        if (sync_hit)
        begin
            // a sync pair restarts the frame wherever we are
            phase_next  = PH_CLASS;
            sum_a_next  = 8'd0;
            sum_b_next  = 8'd0;
            rsum_a_next = 8'd0;
            class_next  = 8'd0;
            msg_next    = 8'd0;
            length_next = 16'd0;
            seen_next   = 16'd0;
        end
        else
        begin
            case (phase_reg)
                PH_HUNT:
                begin
                    phase_next = PH_HUNT;
                end
                PH_CLASS:
                begin
                    class_next = rx_byte;
                    sum_a_next = sum_a_add;
                    sum_b_next = sum_b_add;
                    phase_next = PH_MSG;
                end
                PH_MSG:
                begin
                    msg_next   = rx_byte;
                    sum_a_next = sum_a_add;
                    sum_b_next = sum_b_add;
                    phase_next = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    length_next = {length_reg[15:8], rx_byte};
                    sum_a_next  = sum_a_add;
                    sum_b_next  = sum_b_add;
                    phase_next  = PH_LEN_HI;
                end
                PH_LEN_HI:
                begin
                    length_next = len_hi;
                    sum_a_next  = sum_a_add;
                    sum_b_next  = sum_b_add;
                    if (len_hi > max_len_reg)
                    begin
                        ev         = sfr_pkg::EV_TOO_LONG;
                        phase_next = PH_HUNT;
                    end
                    else if (len_hi == 16'd0)
                    begin
                        phase_next = PH_CK_A;
                    end
                    else
                    begin
                        phase_next = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD:
                begin
                    pv         = 1'b1;
                    pb         = rx_byte;
                    pi         = seen_reg;
                    sum_a_next = sum_a_add;
                    sum_b_next = sum_b_add;
                    seen_next  = seen_inc;
                    if (seen_inc >= length_reg)
                    begin
                        phase_next = PH_CK_A;
                    end
                end
                PH_CK_A:
                begin
                    rsum_a_next = rx_byte;
                    phase_next  = PH_CK_B;
                end
                PH_CK_B:
                begin
                    ev = ((rsum_a_reg == sum_a_reg) && (rx_byte == sum_b_reg)) ?
                         sfr_pkg::EV_GOOD : sfr_pkg::EV_BAD_SUM;
                    phase_next = PH_HUNT;
                end
                default:
                begin
                    phase_next = PH_HUNT;
                end
            endcase
        end
    end

    always_comb
    begin
        result.event_res      = ev;
        result.class_id       = class_next;
        result.message_id     = msg_next;
        result.payload_length = length_next;
        result.payload_valid  = pv;
        result.payload_byte   = pb;
        result.payload_index  = pi;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= MAX_LEN_INIT;
        end
        else if (cfg_we)
        begin
            max_len_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HUNT;
            prev_reg   <= 8'd0;
            sum_a_reg  <= 8'd0;
            sum_b_reg  <= 8'd0;
            rsum_a_reg <= 8'd0;
            class_reg  <= 8'd0;
            msg_reg    <= 8'd0;
            length_reg <= 16'd0;
            seen_reg   <= 16'd0;
        end
        else if (take)
        begin
            phase_reg  <= phase_next;
            prev_reg   <= rx_byte;
            sum_a_reg  <= sum_a_next;
            sum_b_reg  <= sum_b_next;
            rsum_a_reg <= rsum_a_next;
            class_reg  <= class_next;
            msg_reg    <= msg_next;
            length_reg <= length_next;
            seen_reg   <= seen_next;
        end
    end

endmodule

>>> rtl/core/sfr_out_stage.sv
module sfr_out_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load_valid,
    output logic                 load_ready,
    input  sfr_pkg::sfr_result_t load_data,
    sfr_out_if.source            res
);

    logic                 valid_reg;
    sfr_pkg::sfr_result_t data_reg;

    // take a new item while the held one leaves in the same cycle
    assign load_ready = !valid_reg || res.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load_ready)
        begin
            valid_reg <= load_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_ready && load_valid)
        begin
            data_reg <= load_data;
        end
    end

    assign res.valid          = valid_reg;
    assign res.event_res      = data_reg.event_res;
    assign res.class_id       = data_reg.class_id;
    assign res.message_id     = data_reg.message_id;
    assign res.payload_length = data_reg.payload_length;
    assign res.payload_valid  = data_reg.payload_valid;
    assign res.payload_byte   = data_reg.payload_byte;
    assign res.payload_index  = data_reg.payload_index;

endmodule

>>> rtl/core/sync_frame_receiver_fletcher8_unit.sv
// latency: a result is valid the cycle after its byte is accepted
// throughput: one byte per cycle while rx.ready is high
// rx.ready stays high while the result register is empty or being drained
// reset (rst_n, asynchronous, active low) puts the parser in sync hunting,
// clears sums, frame fields and the result valid, and sets max length to MAX_LEN_INIT (119 by default)
module sync_frame_receiver_fletcher8_unit #(
    parameter logic [15:0] MAX_LEN_INIT = sfr_pkg::MAX_LEN_RESET
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    sfr_in_if.sink      rx,
    sfr_out_if.source   res
);

    logic                 in_acc;
    logic                 load_ready;
    sfr_pkg::sfr_result_t parsed;

    assign rx.ready = load_ready;
    assign in_acc   = rx.valid && load_ready;

    sfr_parser #(
        .MAX_LEN_INIT (MAX_LEN_INIT)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .take      (in_acc),
        .rx_byte   (rx.rx_byte),
        .result    (parsed)
    );

    sfr_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (rx.valid),
        .load_ready (load_ready),
        .load_data  (parsed),
        .res        (res)
    );

    a_acc_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> res.valid)
        else $error("accepted item gave no result");

    a_drain_keeps_ready: assert property (@(posedge clk) disable iff (!rst_n)
        res.ready |-> rx.ready)
        else $error("input stalled while result drains");

    a_payload_no_event: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.payload_valid) |-> (res.event_res == sfr_pkg::EV_NONE))
        else $error("event on a payload item");

    a_idle_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && !res.payload_valid) |->
            ((res.payload_byte == 8'd0) && (res.payload_index == 16'd0)))
        else $error("payload fields set on a non-payload item");

endmodule

>>> verif/tb_sync_frame_receiver_fletcher8_unit.sv
`timescale 1ns / 1ps

module tb_sync_frame_receiver_fletcher8_unit;

    localparam int HALF_PERIOD    = 4;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 10;
    localparam int REPORT_LIMIT   = 10;
    localparam int HOLDOFF_CYCLES = 150;
    localparam int PHASE_BYTES    = 125;
    localparam int NO_PAUSE       = -1;

    typedef enum logic [2:0] {
        PH_HUNT, PH_CLASS, PH_MSG, PH_LEN_LO, PH_LEN_HI, PH_PAYLOAD, PH_CK_A, PH_CK_B
    } parse_phase_t;

    typedef enum logic [1:0] {
        FRAME_GOOD, FRAME_BAD_SUM, FRAME_CUT, FRAME_TOO_LONG
    } frame_kind_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_wdata;

    sfr_in_if  rx_ch ();
    sfr_out_if res_ch ();

    sync_frame_receiver_fletcher8_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .rx        (rx_ch),
        .res       (res_ch)
    );

    // parser shadow state
    parse_phase_t phase_q;
    logic [7:0]   prev_byte_q;
    logic [7:0]   sum_a_q;
    logic [7:0]   sum_b_q;
    logic [7:0]   rx_sum_a_q;
    logic [7:0]   class_q;
    logic [7:0]   msg_q;
    logic [15:0]  len_q;
    logic [15:0]  seen_q;
    logic [15:0]  max_len_cfg;

    sfr_pkg::sfr_result_t expected_results[$];
    sfr_pkg::sfr_result_t oldest_expected;

    int idle_pct;
    int stall_pct;
    int holdoff_left;
    int quiet_cycles;
    int bytes_accepted;
    int noise_bytes;
    int results_checked;
    int fail_count;
    int good_frames;
    int bad_sum_frames;
    int too_long_frames;
    int payload_bytes;

    always #HALF_PERIOD clk = ~clk;

    function automatic void fold_into_sum(input logic [7:0] b);
        sum_a_q = sum_a_q + b;
        sum_b_q = sum_b_q + sum_a_q;
    endfunction

    function automatic void parse_rx_byte(input logic [7:0] b);
        sfr_pkg::sfr_result_t r;
        logic [7:0]  prev;
        prev        = prev_byte_q;
        prev_byte_q = b;
        r           = '0;
        r.event_res = sfr_pkg::EV_NONE;
        // a sync pair restarts the frame whatever the phase
        if (b == sfr_pkg::SYNC_SECOND && prev == sfr_pkg::SYNC_FIRST) begin
            phase_q    = PH_CLASS;
            sum_a_q    = '0;
            sum_b_q    = '0;
            rx_sum_a_q = '0;
            class_q    = '0;
            msg_q      = '0;
            len_q      = '0;
            seen_q     = '0;
        end else begin
            case (phase_q)
                PH_CLASS: begin
                    class_q = b;
                    fold_into_sum(b);
                    phase_q = PH_MSG;
                end
                PH_MSG: begin
                    msg_q = b;
                    fold_into_sum(b);
                    phase_q = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    len_q[7:0] = b;
                    fold_into_sum(b);
                    phase_q = PH_LEN_HI;
                end
                PH_LEN_HI: begin
                    len_q[15:8] = b;
                    fold_into_sum(b);
                    if (len_q > max_len_cfg) begin
                        r.event_res = sfr_pkg::EV_TOO_LONG;
                        phase_q     = PH_HUNT;
                    end else if (len_q == 16'd0) begin
                        phase_q = PH_CK_A;
                    end else begin
                        phase_q = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    r.payload_valid = 1'b1;
                    r.payload_byte  = b;
                    r.payload_index = seen_q;
                    fold_into_sum(b);
                    seen_q = seen_q + 16'd1;
                    if (seen_q >= len_q)
                        phase_q = PH_CK_A;
                end
                PH_CK_A: begin
                    rx_sum_a_q = b;
                    phase_q    = PH_CK_B;
                end
                PH_CK_B: begin
                    r.event_res = (rx_sum_a_q == sum_a_q && b == sum_b_q) ?
                                  sfr_pkg::EV_GOOD : sfr_pkg::EV_BAD_SUM;
                    phase_q = PH_HUNT;
                end
                default: ;
            endcase
        end
        r.class_id       = class_q;
        r.message_id     = msg_q;
        r.payload_length = len_q;
        expected_results = {expected_results, r};
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            if (fail_count < REPORT_LIMIT)
                $display("mismatch in result %0d: %s expected 0x%0h, got 0x%0h",
                         results_checked, name, want, got);
            fail_count++;
        end
    endtask

    // result checker
    always @(posedge clk) begin
        if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
            if (expected_results.size() == 0) begin
                if (fail_count < REPORT_LIMIT)
                    $display("result %0d arrived with nothing expected", results_checked);
                fail_count++;
            end else begin
                oldest_expected = expected_results.pop_front();
                check_field("event_res", 16'(oldest_expected.event_res),
                            16'(res_ch.event_res));
                check_field("class_id", 16'(oldest_expected.class_id),
                            16'(res_ch.class_id));
                check_field("message_id", 16'(oldest_expected.message_id),
                            16'(res_ch.message_id));
                check_field("payload_length", oldest_expected.payload_length,
                            res_ch.payload_length);
                check_field("payload_valid", 16'(oldest_expected.payload_valid),
                            16'(res_ch.payload_valid));
                check_field("payload_byte", 16'(oldest_expected.payload_byte),
                            16'(res_ch.payload_byte));
                check_field("payload_index", oldest_expected.payload_index,
                            res_ch.payload_index);
                case (oldest_expected.event_res)
                    sfr_pkg::EV_GOOD:     good_frames++;
                    sfr_pkg::EV_BAD_SUM:  bad_sum_frames++;
                    sfr_pkg::EV_TOO_LONG: too_long_frames++;
                    default: ;
                endcase
                if (oldest_expected.payload_valid)
                    payload_bytes++;
            end
            results_checked++;
        end
    end

    // result side: random stalls plus an occasional long hold-off
    always @(negedge clk) begin
        if (holdoff_left > 0) begin
            res_ch.ready <= 1'b0;
            holdoff_left--;
        end else begin
            res_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk) begin
        if ((rx_ch.valid === 1'b1 && rx_ch.ready === 1'b1) ||
            (res_ch.valid === 1'b1 && res_ch.ready === 1'b1))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct) begin
            rx_ch.valid   <= 1'b0;
            rx_ch.rx_byte <= 8'($urandom);
            @(negedge clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        do @(posedge clk); while (rx_ch.ready !== 1'b1);
        parse_rx_byte(b);
        bytes_accepted++;
    endtask

    task automatic send_sequence(input logic [7:0] seq[$]);
        foreach (seq[i])
            send_byte(seq[i]);
    endtask

    task automatic wait_results_drained();
        @(negedge clk);
        rx_ch.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_max_len(input logic [15:0] value);
        wait_results_drained();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we      <= 1'b0;
        max_len_cfg  = value;
    endtask

    task automatic send_frame(input logic [7:0] cls, input logic [7:0] msg,
                              input logic [15:0] len, input frame_kind_t kind,
                              input int pause_at);
        logic [7:0] bytes_q[$];
        logic [7:0] ck_a;
        logic [7:0] ck_b;
        int         cut;
        bytes_q = {sfr_pkg::SYNC_FIRST, sfr_pkg::SYNC_SECOND, cls, msg, len[7:0], len[15:8]};
        if (kind != FRAME_TOO_LONG) begin
            for (int i = 0; i < int'(len); i++)
                bytes_q = {bytes_q, 8'($urandom)};
            ck_a = '0;
            ck_b = '0;
            for (int i = 2; i < bytes_q.size(); i++) begin
                ck_a = ck_a + bytes_q[i];
                ck_b = ck_b + ck_a;
            end
            if (kind == FRAME_BAD_SUM) begin
                if ($urandom_range(1))
                    ck_a = ck_a ^ (8'h01 << $urandom_range(7));
                else
                    ck_b = ck_b ^ (8'h01 << $urandom_range(7));
            end
            bytes_q = {bytes_q, ck_a, ck_b};
            // a cut frame is left unfinished; the next sync pair takes over
            if (kind == FRAME_CUT) begin
                cut = $urandom_range(bytes_q.size() - 1, 3);
                while (bytes_q.size() > cut)
                    void'(bytes_q.pop_back());
            end
        end
        foreach (bytes_q[i]) begin
            if (i == pause_at)
                wait_results_drained();
            send_byte(bytes_q[i]);
        end
    endtask

    task automatic test_directed_frames();
        logic [7:0] seq[$];
        idle_pct  = 0;
        stall_pct = 0;
        // restart by a sync pair that begins in a payload, then an empty payload with a zero checksum
        seq = {8'hB5, 8'h62, 8'hFF, 8'hFF, 8'h02, 8'h00, 8'hFF, 8'hB5, 8'h62,
               8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
        send_sequence(seq);
        seq = {8'hB5, 8'h62, 8'h80, 8'h01, 8'h01, 8'h00, 8'h5A, 8'h00, 8'h00};
        send_sequence(seq);
        // lone second sync byte while hunting, then 120 against the reset limit
        seq = {8'h62, 8'hB5, 8'h62, 8'h01, 8'h02, 8'h78, 8'h00};
        send_sequence(seq);
    endtask

    task automatic test_length_limit();
        logic [7:0] seq[$];
        write_max_len(16'd0);
        send_frame(8'($urandom), 8'($urandom), 16'd0, FRAME_GOOD, NO_PAUSE);
        send_frame(8'($urandom), 8'($urandom), 16'd1, FRAME_TOO_LONG, NO_PAUSE);
        write_max_len(16'hFFFF);
        seq = {8'hB5, 8'h62, 8'h01, 8'h01, 8'hFF, 8'hFF, 8'hAB, 8'hCD};
        send_sequence(seq);
        send_frame(8'($urandom), 8'($urandom), 16'd3, FRAME_GOOD, NO_PAUSE);
        write_max_len(16'd1);
        send_frame(8'($urandom), 8'($urandom), 16'd1, FRAME_GOOD, NO_PAUSE);
        send_frame(8'($urandom), 8'($urandom), 16'd2, FRAME_TOO_LONG, NO_PAUSE);
        write_max_len(sfr_pkg::MAX_LEN_RESET);
    endtask

    task automatic test_receiver_holdoff();
        write_max_len(sfr_pkg::MAX_LEN_RESET);
        idle_pct     = 0;
        stall_pct    = 0;
        holdoff_left = HOLDOFF_CYCLES;
        send_frame(8'($urandom), 8'($urandom), 16'd24, FRAME_GOOD, NO_PAUSE);
        wait_results_drained();
    endtask

    task automatic test_sender_pause();
        idle_pct  = 7;
        stall_pct = 7;
        send_frame(8'($urandom), 8'($urandom), 16'd10, FRAME_GOOD, 8);
        send_frame(8'($urandom), 8'($urandom), 16'd4, FRAME_BAD_SUM, 4);
        wait_results_drained();
    endtask

    task automatic run_random_frames(input int n_bytes);
        int          target;
        int          roll;
        int          top;
        logic [15:0] len;
        frame_kind_t kind;
        target = bytes_accepted - noise_bytes + n_bytes;
        while (bytes_accepted - noise_bytes < target) begin
            roll = $urandom_range(99);
            if (roll < 8) begin
                repeat ($urandom_range(4, 1)) begin
                    send_byte(8'($urandom));
                    noise_bytes++;
                end
            end else begin
                if (roll < 16 && max_len_cfg != 16'hFFFF) begin
                    kind = FRAME_TOO_LONG;
                    len  = 16'($urandom_range(16'hFFFF, int'(max_len_cfg) + 1));
                end else begin
                    if (roll < 28)
                        kind = FRAME_BAD_SUM;
                    else if (roll < 38)
                        kind = FRAME_CUT;
                    else
                        kind = FRAME_GOOD;
                    // mostly short payloads, now and then a longer one
                    top = ($urandom_range(9) == 0) ? 120 : 12;
                    if (int'(max_len_cfg) < top)
                        top = int'(max_len_cfg);
                    len = 16'($urandom_range(top, 0));
                end
                send_frame(8'($urandom), 8'($urandom), len, kind, NO_PAUSE);
            end
        end
    endtask

    task automatic test_random_traffic();
        write_max_len(sfr_pkg::MAX_LEN_RESET);
        idle_pct  = 0;
        stall_pct = 0;
        run_random_frames(PHASE_BYTES);
        write_max_len(16'($urandom_range(40, 8)));
        idle_pct  = 63;
        stall_pct = 0;
        run_random_frames(PHASE_BYTES);
        write_max_len(16'hFFFF);
        idle_pct  = 0;
        stall_pct = 63;
        run_random_frames(PHASE_BYTES);
        write_max_len(16'($urandom_range(255, 0)));
        idle_pct  = 7;
        stall_pct = 7;
        run_random_frames(PHASE_BYTES);
        wait_results_drained();
    endtask

    initial begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        rx_ch.valid   = 1'b0;
        rx_ch.rx_byte = '0;
        res_ch.ready  = 1'b0;
        idle_pct      = 0;
        stall_pct     = 0;
        holdoff_left  = 0;
        phase_q       = PH_HUNT;
        prev_byte_q   = '0;
        sum_a_q       = '0;
        sum_b_q       = '0;
        rx_sum_a_q    = '0;
        class_q       = '0;
        msg_q         = '0;
        len_q         = '0;
        seen_q        = '0;
        max_len_cfg   = sfr_pkg::MAX_LEN_RESET;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_frames();
        test_length_limit();
        test_receiver_holdoff();
        test_sender_pause();
        test_random_traffic();

        wait_results_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("checked %0d results from %0d bytes: %0d good, %0d bad checksum,",
                 results_checked, bytes_accepted, good_frames, bad_sum_frames);
        $display("%0d too long, %0d payload bytes; limits 0, 1, 119, 65535 and random",
                 too_long_frames, payload_bytes);
        if (fail_count == 0 && expected_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> files.f
rtl/core/sfr_pkg.sv
rtl/core/sfr_ifs.sv
rtl/core/sfr_parser.sv
rtl/core/sfr_out_stage.sv
rtl/core/sync_frame_receiver_fletcher8_unit.sv
verif/tb_sync_frame_receiver_fletcher8_unit.sv
